/* rtl/efvg_pkg.sv */
// Shared types and constants for the ellipse fan vertex generator.
`timescale 1ns / 1ps

package efvg_pkg;

    localparam int IDX_W       = 10;
    localparam int TOT_W       = 11;
    localparam int HALF_W      = 16;
    localparam int OUT_W       = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [TOT_W-1:0] MAX_VERTICES = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_TOTAL = 2'd2;

    localparam int QUO_W        = 32;
    localparam int DIV_BITS     = 4;
    localparam int DIV_STAGES   = QUO_W / DIV_BITS;

    localparam int CORDIC_STEPS = 24;
    localparam int CW           = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Per-item information that rides alongside the arithmetic.
    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             tri_ok;
        logic             err;
        logic [1:0]       quad;
    } side_t;

endpackage

/* rtl/efvg_if.sv */
// Valid/ready channel interfaces for vertex requests and vertex results.
`timescale 1ns / 1ps

interface efvg_in_if;
    logic       valid;
    logic       ready;
    logic [9:0] vertex_index;

    modport source (output valid, output vertex_index, input ready);
    modport sink   (input valid, input vertex_index, output ready);
endinterface

interface efvg_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic               tri_valid;
    logic [9:0]         tri_second;
    logic [9:0]         tri_third;
    logic               index_error;

    modport source (output valid, output pos_x, output pos_y, output tex_u, output tex_v,
                    output tri_valid, output tri_second, output tri_third,
                    output index_error, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input tex_u, input tex_v,
                    input tri_valid, input tri_second, input tri_third,
                    input index_error, output ready);
endinterface

/* rtl/efvg_div.sv */
// Pipelined restoring divider that forms the rounded vertex phase fraction.
`timescale 1ns / 1ps

module efvg_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [10:0]           in_rem,
    input  efvg_pkg::side_t       in_side,
    input  logic [10:0]           tot,
    output logic                  out_valid,
    output logic [31:0]           out_quo,
    output efvg_pkg::side_t       out_side
);
    import efvg_pkg::*;

    logic [TOT_W-1:0] rem_pipe   [DIV_STAGES+1];
    logic [QUO_W-1:0] quo_pipe   [DIV_STAGES+1];
    side_t            side_pipe  [DIV_STAGES+1];
    logic [DIV_STAGES:0] valid_pipe;
    logic [QUO_W-1:0] num_low;

    // Low numerator word is half the total, which makes the quotient round to nearest.
    assign num_low = {{(QUO_W-TOT_W+1){1'b0}}, tot[TOT_W-1:1]};

    assign rem_pipe[0]   = in_rem;
    assign quo_pipe[0]   = '0;
    assign side_pipe[0]  = in_side;
    assign valid_pipe[0] = in_valid;

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [TOT_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;
        logic [TOT_W-1:0] rem_reg;
        logic [QUO_W-1:0] quo_reg;
        side_t            side_reg;
        logic             valid_reg;

        always_comb
        begin
            logic [TOT_W:0] sh;
            rem_next = rem_pipe[s];
            quo_next = quo_pipe[s];
            for (int k = 0; k < DIV_BITS; k++) begin
                sh = {rem_next, num_low[QUO_W-1-DIV_BITS*s-k]};
                if (sh >= {1'b0, tot})
                begin
                    rem_next = TOT_W'(sh - {1'b0, tot});
                    quo_next = {quo_next[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = sh[TOT_W-1:0];
                    quo_next = {quo_next[QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (en)
            begin
                valid_reg <= valid_pipe[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                quo_reg  <= quo_next;
                side_reg <= side_pipe[s];
            end
        end

        assign rem_pipe[s+1]   = rem_reg;
        assign quo_pipe[s+1]   = quo_reg;
        assign side_pipe[s+1]  = side_reg;
        assign valid_pipe[s+1] = valid_reg;
    end

    assign out_valid = valid_pipe[DIV_STAGES];
    assign out_quo   = quo_pipe[DIV_STAGES];
    assign out_side  = side_pipe[DIV_STAGES];

endmodule

/* rtl/efvg_cordic.sv */
// Quadrant reduction and pipelined rotation CORDIC giving cosine and sine in Q4.30.
`timescale 1ns / 1ps

module efvg_cordic (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [31:0]           in_frac,
    input  efvg_pkg::side_t       in_side,
    output logic                  out_valid,
    output logic signed [33:0]    out_x,
    output logic signed [33:0]    out_y,
    output efvg_pkg::side_t       out_side
);
    import efvg_pkg::*;

    logic signed [CW-1:0] x_pipe [CORDIC_STEPS+1];
    logic signed [CW-1:0] y_pipe [CORDIC_STEPS+1];
    logic signed [CW-1:0] z_pipe [CORDIC_STEPS+1];
    side_t                side_pipe [CORDIC_STEPS+1];
    logic [CORDIC_STEPS:0] valid_pipe;

    logic [31:0] phase;
    logic [31:0] phase_bias;
    logic [1:0]  quad;
    logic [31:0] resid;
    side_t       side_next;

    logic signed [CW-1:0] z_reg;
    side_t                prep_side_reg;
    logic                 prep_valid_reg;

    // A quarter turn is added so index zero lands at the top.
    assign phase      = in_frac + 32'h4000_0000;
    assign phase_bias = phase + 32'h2000_0000;
    assign quad       = phase_bias[31:30];
    assign resid      = phase - {quad, 30'd0};

    always_comb
    begin
        side_next      = in_side;
        side_next.quad = quad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            prep_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg         <= CW'(signed'(resid));
            prep_side_reg <= side_next;
        end
    end

    assign x_pipe[0]     = CORDIC_GAIN;
    assign y_pipe[0]     = '0;
    assign z_pipe[0]     = z_reg;
    assign side_pipe[0]  = prep_side_reg;
    assign valid_pipe[0] = prep_valid_reg;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        logic signed [CW-1:0] x_next, y_next, z_next;
        logic signed [CW-1:0] x_reg, y_reg, zs_reg;
        side_t                side_reg;
        logic                 valid_reg;
        logic signed [CW-1:0] dx, dy, da;

        assign dx = y_pipe[k] >>> k;
        assign dy = x_pipe[k] >>> k;
        assign da = CW'(signed'({1'b0, ATAN_TURNS[k]}));

        always_comb
        begin
            if (!z_pipe[k][CW-1])
            begin
                x_next = x_pipe[k] - dx;
                y_next = y_pipe[k] + dy;
                z_next = z_pipe[k] - da;
            end
            else
            begin
                x_next = x_pipe[k] + dx;
                y_next = y_pipe[k] - dy;
                z_next = z_pipe[k] + da;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (en)
            begin
                valid_reg <= valid_pipe[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg    <= x_next;
                y_reg    <= y_next;
                zs_reg   <= z_next;
                side_reg <= side_pipe[k];
            end
        end

        assign x_pipe[k+1]     = x_reg;
        assign y_pipe[k+1]     = y_reg;
        assign z_pipe[k+1]     = zs_reg;
        assign side_pipe[k+1]  = side_reg;
        assign valid_pipe[k+1] = valid_reg;
    end

    assign out_valid = valid_pipe[CORDIC_STEPS];
    assign out_x     = x_pipe[CORDIC_STEPS];
    assign out_y     = y_pipe[CORDIC_STEPS];
    assign out_side  = side_pipe[CORDIC_STEPS];

endmodule

/* rtl/ellipse_fan_vertex_generator_top.sv */
// Top level of the ellipse fan vertex generator: config, pipeline control and output stages.
`timescale 1ns / 1ps

// Takes one vertex index per transaction and returns one vertex per transaction, at a
// sustained rate of one per clock while the output is not stalled. The pipeline is 8 divider
// stages (4 quotient bits each), one quadrant stage, 24 CORDIC stages (one rotation each), and
// three output stages for Q2.15 rounding, the scaling multiply and final rounding. The whole
// pipeline advances together whenever the output register is empty or being taken, so a stall
// holds every item in place. Configuration must only be written while the pipeline is empty.

module ellipse_fan_vertex_generator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    efvg_in_if.sink     in_ch,
    efvg_out_if.source  out_ch
);
    import efvg_pkg::*;

    logic [HALF_W-1:0] half_width_reg;
    logic [HALF_W-1:0] half_height_reg;
    logic [TOT_W-1:0]  vertex_total_reg;
    logic [TOT_W-1:0]  tot;
    logic              en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg   <= 16'd256;
            half_height_reg  <= 16'd256;
            vertex_total_reg <= 11'd32;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_HALF_WIDTH:   half_width_reg   <= cfg_data;
                REG_HALF_HEIGHT:  half_height_reg  <= cfg_data;
                REG_VERTEX_TOTAL: vertex_total_reg <= cfg_data[TOT_W-1:0];
                default: ;
            endcase
        end
    end

    assign tot = (vertex_total_reg > MAX_VERTICES) ? MAX_VERTICES : vertex_total_reg;

    // Output register empty or being drained lets every stage move.
    assign en          = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = en;

    side_t             in_side;
    logic [IDX_W+1:0]  idx_plus2;

    assign idx_plus2 = {2'b00, in_ch.vertex_index} + 12'd2;

    always_comb
    begin
        in_side.index  = in_ch.vertex_index;
        in_side.err    = ({1'b0, in_ch.vertex_index} >= tot);
        in_side.tri_ok = (in_ch.vertex_index != '0) && (idx_plus2 <= {1'b0, tot});
        in_side.quad   = 2'd0;
    end

    logic        div_valid;
    logic [31:0] div_quo;
    side_t       div_side;

    efvg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_ch.valid),
        .in_rem    ({1'b0, in_ch.vertex_index}),
        .in_side   (in_side),
        .tot       (tot),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_side  (div_side)
    );

    logic                 cor_valid;
    logic signed [CW-1:0] cor_x, cor_y;
    side_t                cor_side;

    efvg_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in_frac   (div_quo),
        .in_side   (div_side),
        .out_valid (cor_valid),
        .out_x     (cor_x),
        .out_y     (cor_y),
        .out_side  (cor_side)
    );

    function automatic logic signed [OUT_W-1:0] to_q15(input logic signed [CW-1:0] v);
        logic signed [CW:0]    t;
        logic signed [CW-15:0] r;
        t = {v[CW-1], v} + 35'sd16384;
        r = (CW-14)'(t >>> 15);
        if (r > 20'sd32768)
        begin
            return 17'sd32768;
        end
        else if (r < -20'sd32768)
        begin
            return -17'sd32768;
        end
        return r[OUT_W-1:0];
    endfunction

    // Stage A: round to Q2.15 and undo the quadrant reduction.
    logic signed [OUT_W-1:0] c15, s15;
    logic signed [OUT_W-1:0] cf_next, sf_next;
    logic signed [OUT_W-1:0] cf_a_reg, sf_a_reg;
    side_t                   side_a_reg;
    logic                    valid_a_reg;

    assign c15 = to_q15(cor_x);
    assign s15 = to_q15(cor_y);

    always_comb
    begin
        case (cor_side.quad)
            2'd0:    begin cf_next = c15;  sf_next = s15;  end
            2'd1:    begin cf_next = -s15; sf_next = c15;  end
            2'd2:    begin cf_next = -c15; sf_next = -s15; end
            default: begin cf_next = s15;  sf_next = -c15; end
        endcase
    end

    // Stage B: scale by the half axes.
    logic signed [OUT_W+HALF_W-1:0] px_next, py_next;
    logic signed [OUT_W+HALF_W-1:0] px_b_reg, py_b_reg;
    logic signed [OUT_W-1:0]        cf_b_reg, sf_b_reg;
    side_t                          side_b_reg;
    logic                           valid_b_reg;

    assign px_next = cf_a_reg * signed'({1'b0, half_width_reg});
    assign py_next = sf_a_reg * signed'({1'b0, half_height_reg});

    // Stage C: final rounding into the output register.
    logic signed [OUT_W+HALF_W-1:0] px_rnd, py_rnd;
    logic signed [OUT_W+HALF_W-1:0] px_sh, py_sh;
    logic [OUT_W-1:0]               u_val, v_val;

    assign px_rnd = px_b_reg + (OUT_W+HALF_W)'(33'sd16384);
    assign py_rnd = py_b_reg + (OUT_W+HALF_W)'(33'sd16384);
    assign px_sh  = px_rnd >>> 15;
    assign py_sh  = py_rnd >>> 15;
    assign u_val  = OUT_W'(17'sd32768 + cf_b_reg);
    assign v_val  = OUT_W'(17'sd32768 - sf_b_reg);

    logic               out_valid_reg;
    logic signed [16:0] pos_x_reg, pos_y_reg;
    logic [16:0]        tex_u_reg, tex_v_reg;
    logic               tri_valid_reg, index_error_reg;
    logic [9:0]         tri_second_reg, tri_third_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg   <= 1'b0;
            valid_b_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg   <= cor_valid;
            valid_b_reg   <= valid_a_reg;
            out_valid_reg <= valid_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cf_a_reg   <= cf_next;
            sf_a_reg   <= sf_next;
            side_a_reg <= cor_side;

            px_b_reg   <= px_next;
            py_b_reg   <= py_next;
            cf_b_reg   <= cf_a_reg;
            sf_b_reg   <= sf_a_reg;
            side_b_reg <= side_a_reg;

            if (side_b_reg.err)
            begin
                pos_x_reg <= '0;
                pos_y_reg <= '0;
                tex_u_reg <= '0;
                tex_v_reg <= '0;
            end
            else
            begin
                pos_x_reg <= px_sh[OUT_W-1:0];
                pos_y_reg <= py_sh[OUT_W-1:0];
                tex_u_reg <= u_val;
                tex_v_reg <= v_val;
            end
            index_error_reg <= side_b_reg.err;
            tri_valid_reg   <= side_b_reg.tri_ok;
            tri_second_reg  <= side_b_reg.tri_ok ? side_b_reg.index : '0;
            tri_third_reg   <= side_b_reg.tri_ok ? IDX_W'(side_b_reg.index + 10'd1) : '0;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.pos_x       = pos_x_reg;
    assign out_ch.pos_y       = pos_y_reg;
    assign out_ch.tex_u       = tex_u_reg;
    assign out_ch.tex_v       = tex_v_reg;
    assign out_ch.tri_valid   = tri_valid_reg;
    assign out_ch.tri_second  = tri_second_reg;
    assign out_ch.tri_third   = tri_third_reg;
    assign out_ch.index_error = index_error_reg;

endmodule

/* tb/efvg_tb_if.sv */
// Result record type that the testbench scoreboard keeps for each expected vertex.
`timescale 1ns / 1ps

package efvg_tb_types;

    typedef struct {
        logic signed [16:0] pos_x;
        logic signed [16:0] pos_y;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
        logic               tri_valid;
        logic [9:0]         tri_second;
        logic [9:0]         tri_third;
        logic               index_error;
    } vertex_t;

endpackage

/* tb/testbench.sv */
// Testbench for the ellipse fan vertex generator: predicts each vertex and checks results.
`timescale 1ns / 1ps

module testbench;
    import efvg_pkg::*;
    import efvg_tb_types::*;

    localparam int LATENCY = 36;

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    efvg_in_if  in_ch ();
    efvg_out_if out_ch ();

    ellipse_fan_vertex_generator_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_ch        (in_ch.sink),
        .out_ch       (out_ch.source)
    );

    // Shadow copy of the configuration registers.
    logic [15:0] cur_half_width;
    logic [15:0] cur_half_height;
    logic [10:0] cur_vertex_total;

    vertex_t expected_vertices[$];
    int      error_count;
    bit      hold_off_long;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic longint shift_floor(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint round_q15(longint v);
        longint r;
        r = shift_floor(v + (64'sd1 <<< 14), 15);
        if (r > 32768)
            r = 32768;
        if (r < -32768)
            r = -32768;
        return r;
    endfunction

    function automatic logic [16:0] scale_half(longint t, logic [15:0] half);
        longint p;
        p = t * longint'(half);
        return 17'(shift_floor(p + (64'sd1 <<< 14), 15));
    endfunction

    function automatic vertex_t predict_vertex(logic [9:0] idx);
        vertex_t v;
        longint unsigned total, frac;
        logic [31:0] phase, resid;
        logic [1:0]  quad;
        longint z, x, y, dx, dy, c, s, cf, sf;
        int unsigned atan_tab [24] = '{
            536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10679838, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861, 10430, 5215,
            2608, 1304, 652, 326, 163, 81};
        v = '{default: '0};
        total = cur_vertex_total;
        if (total > 1024)
            total = 1024;
        if (longint'(idx) >= total)
        begin
            v.index_error = 1'b1;
            return v;
        end
        frac = ((longint'(idx) << 32) + total / 2) / total;
        phase = 32'(frac + 64'h4000_0000);
        quad = 2'((phase + 32'h2000_0000) >> 30);
        resid = phase - ({30'd0, quad} << 30);
        z = longint'($signed(resid));
        x = 652032874;
        y = 0;
        for (int k = 0; k < 24; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(atan_tab[k]);
            end
            else
            begin
                x += dx; y -= dy; z += longint'(atan_tab[k]);
            end
        end
        c = round_q15(x);
        s = round_q15(y);
        case (quad)
            2'd0: begin cf = c;  sf = s;  end
            2'd1: begin cf = -s; sf = c;  end
            2'd2: begin cf = -c; sf = -s; end
            default: begin cf = s; sf = -c; end
        endcase
        v.pos_x = scale_half(cf, cur_half_width);
        v.pos_y = scale_half(sf, cur_half_height);
        v.tex_u = 17'(32768 + cf);
        v.tex_v = 17'(32768 - sf);
        if (idx >= 1 && longint'(idx) + 2 <= total)
        begin
            v.tri_valid  = 1'b1;
            v.tri_second = idx;
            v.tri_third  = idx + 10'd1;
        end
        return v;
    endfunction

    // Holds the write enable high; the caller drops it after the last write.
    task automatic write_register(logic [1:0] reg_index, logic [15:0] value);
        cfg_write_en <= 1'b1;
        cfg_index    <= reg_index;
        cfg_data     <= value;
        @(posedge clk);
        case (reg_index)
            REG_HALF_WIDTH:   cur_half_width   = value;
            REG_HALF_HEIGHT:  cur_half_height  = value;
            REG_VERTEX_TOTAL: cur_vertex_total = value[10:0];
            default: ;
        endcase
    endtask

    // Sends one vertex index; the expectation is queued when the transaction completes.
    task automatic send_index(logic [9:0] idx);
        in_ch.valid        <= 1'b1;
        in_ch.vertex_index <= idx;
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_vertices.insert(expected_vertices.size(), predict_vertex(idx));
    endtask

    task automatic release_input();
        in_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        release_input();
        while (expected_vertices.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic configure(logic [15:0] hw, logic [15:0] hh, logic [15:0] tot);
        drain();
        write_register(REG_HALF_WIDTH, hw);
        write_register(REG_HALF_HEIGHT, hh);
        write_register(REG_VERTEX_TOTAL, tot);
        cfg_write_en <= 1'b0;
    endtask

    // Bursts of back-to-back transactions separated by random gaps.
    task automatic send_random(int count, bit mostly_valid);
        int burst;
        logic [9:0] idx;
        for (int n = 0; n < count; n++)
        begin
            if (mostly_valid && cur_vertex_total != 0 && $urandom_range(0, 9) != 0)
                idx = 10'($urandom_range(0,
                          (cur_vertex_total > 1024 ? 1024 : cur_vertex_total) - 1));
            else
                idx = 10'($urandom);
            send_index(idx);
            if (burst <= 0)
            begin
                burst = $urandom_range(0, 12);
                if ($urandom_range(0, 1))
                begin
                    release_input();
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
            end
            burst--;
        end
    endtask

    task automatic test_reset_defaults();
        for (int i = 0; i < 34; i += 3)
            send_index(10'(i));
        send_index(10'd31);
        send_index(10'd1023);
        drain();
    endtask

    task automatic test_extremes();
        configure(16'hFFFF, 16'hFFFF, 16'd1024);
        send_index(10'd0);
        send_index(10'd256);
        send_index(10'd512);
        send_index(10'd768);
        send_index(10'd1022);
        send_index(10'd1023);
        configure(16'd0, 16'd0, 16'd1);
        send_index(10'd0);
        send_index(10'd1);
        configure(16'd300, 16'd77, 16'd0);
        send_index(10'd0);
        configure(16'd512, 16'd128, 16'd2047);
        send_index(10'd1023);
        send_index(10'd500);
        configure(16'd1000, 16'd900, 16'd3);
        send_index(10'd0);
        send_index(10'd1);
        send_index(10'd2);
        send_index(10'd3);
        drain();
    endtask

    task automatic test_random_configs();
        for (int p = 0; p < 10; p++)
        begin
            configure(16'($urandom), 16'($urandom),
                      16'($urandom_range(0, 9) == 0 ? $urandom_range(0, 2047)
                                                    : $urandom_range(1, 1024)));
            send_random(100, 1'b1);
        end
        drain();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering.
    task automatic test_backpressure();
        configure(16'h1234, 16'h0800, 16'd700);
        hold_off_long = 1'b1;
        send_random(150, 1'b1);
        drain();
        send_random(50, 1'b1);
        drain();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_write_en       = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        in_ch.valid        = 1'b0;
        in_ch.vertex_index = '0;
        out_ch.ready       = 1'b0;
        error_count        = 0;
        hold_off_long      = 1'b0;
        cur_half_width     = 16'd256;
        cur_half_height    = 16'd256;
        cur_vertex_total   = 11'd32;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_extremes();
        test_random_configs();
        test_backpressure();
        drain();
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Receiver stall pattern: periods of free flow, random stalls, and one long hold-off.
    initial
    begin
        int phase_cnt;
        phase_cnt = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_long)
            begin
                out_ch.ready <= 1'b0;
                repeat (200) @(posedge clk);
                hold_off_long = 1'b0;
            end
            phase_cnt++;
            if ((phase_cnt / 64) % 3 == 0)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Compares each result transaction with the oldest expectation.
    initial
    begin
        vertex_t exp_v;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                if (expected_vertices.size() == 0)
                begin
                    $display("%0t: result with no expectation pending", $time);
                    error_count++;
                end
                else
                begin
                    exp_v = expected_vertices.pop_front();
                    if (out_ch.pos_x !== exp_v.pos_x || out_ch.pos_y !== exp_v.pos_y ||
                        out_ch.tex_u !== exp_v.tex_u || out_ch.tex_v !== exp_v.tex_v ||
                        out_ch.tri_valid !== exp_v.tri_valid ||
                        out_ch.tri_second !== exp_v.tri_second ||
                        out_ch.tri_third !== exp_v.tri_third ||
                        out_ch.index_error !== exp_v.index_error)
                    begin
                        $display("%0t: mismatch expected x=%0d y=%0d u=%0d v=%0d t=%b %0d %0d e=%b",
                                 $time, exp_v.pos_x, exp_v.pos_y, exp_v.tex_u, exp_v.tex_v,
                                 exp_v.tri_valid, exp_v.tri_second, exp_v.tri_third,
                                 exp_v.index_error);
                        $display("%0t: mismatch actual   x=%0d y=%0d u=%0d v=%0d t=%b %0d %0d e=%b",
                                 $time, out_ch.pos_x, out_ch.pos_y, out_ch.tex_u, out_ch.tex_v,
                                 out_ch.tri_valid, out_ch.tri_second, out_ch.tri_third,
                                 out_ch.index_error);
                        error_count++;
                    end
                end
            end
        end
    end

endmodule

/* files.f */
rtl/efvg_pkg.sv
rtl/efvg_if.sv
rtl/efvg_div.sv
rtl/efvg_cordic.sv
rtl/ellipse_fan_vertex_generator_top.sv
tb/efvg_tb_if.sv
tb/testbench.sv
